// ===== src/lz_escape_token_decoder_assert.svh =====
// Assertion helpers for the escape-token decoder checker.
// Both macros sample on the rising clock edge and are off while reset is high.
`ifndef LZ_ESCAPE_TOKEN_DECODER_ASSERT_SVH
`define LZ_ESCAPE_TOKEN_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LZD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lzd_pkg.sv =====
package lzd_pkg;

   localparam int BYTE_W        = 8;
   localparam int HISTORY_DEPTH = 256;
   localparam int RING_AW       = $clog2(HISTORY_DEPTH);
   localparam int MAX_COPY      = 64;

   typedef enum logic [2:0] {
      ST_LIT,
      ST_ESC,
      ST_DIST,
      ST_READ,
      ST_WRITE
   } lzd_state_type;

   typedef struct packed {
      logic lit_load;
      logic hold_dist;
      logic start_copy;
      logic rd_issue;
      logic copy_emit;
   } lzd_cmd_type;

   typedef struct packed {
      logic is_esc;
      logic len_zero;
      logic copy_last;
      logic out_free;
   } lzd_status_type;

endpackage

// ===== src/lzd_if.sv =====
interface lzd_req_if;
   import lzd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] comp_byte;
   logic              block_end;

   modport source (output valid, output comp_byte, output block_end, input ready);
   modport sink   (input valid, input comp_byte, input block_end, output ready);
endinterface

interface lzd_rsp_if;
   import lzd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              run_last;
   logic              length_error;

   modport source (output valid, output out_byte, output run_last, output length_error,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input length_error,
                   output ready);
endinterface

// ===== src/lz_escape_token_decoder.sv =====
// A literal shows on rsp in the cycle after its request is accepted.
// Throughput: one literal request per cycle while rsp is ready; a back-reference
//   emits each byte by a ring read, then a write-back and output load that waits
//   for the output register to be free, and input waits until the copy is done.
// Reset (synchronous, active high) clears the parser, the escape byte, the write
//   pointer and the per-slot valid bits of the history ring, which read as zero.
module lz_escape_token_decoder #(
   parameter int COPY_LIMIT = lzd_pkg::MAX_COPY
) (
   input  logic                       clock,
   input  logic                       reset,
   lzd_req_if.sink                    req_chan,
   lzd_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [lzd_pkg::BYTE_W-1:0] csr_wr_data
);
   import lzd_pkg::*;

   lzd_cmd_type    cmd;
   lzd_status_type status;

   // Parser and copy sequencer: decides what each request means and paces
   // the copy loop against the output register.
   lzd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_block_end (req_chan.block_end),
      .req_ready     (req_chan.ready),
      .status        (status),
      .cmd           (cmd)
   );

   // History ring, token registers, copy counter and the output register that
   // holds a finished byte until rsp takes it.
   lzd_dp #(
      .COPY_LIMIT (COPY_LIMIT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_comp_byte    (req_chan.comp_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_out_byte     (rsp_chan.out_byte),
      .rsp_run_last     (rsp_chan.run_last),
      .rsp_length_error (rsp_chan.length_error)
   );

endmodule

// ===== src/lzd_ctrl.sv =====
module lzd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_block_end,
   output logic                    req_ready,
   input  lzd_pkg::lzd_status_type status,
   output lzd_pkg::lzd_cmd_type    cmd
);
   import lzd_pkg::*;

   lzd_state_type state_ff, state_in;
   logic          accept;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LIT: begin
            if (accept && status.is_esc && !req_block_end) begin
               state_in = ST_ESC;
            end
         end
         ST_ESC: begin
            if (accept) begin
               if (status.is_esc || req_block_end) begin
                  state_in = ST_LIT;
               end else begin
                  state_in = ST_DIST;
               end
            end
         end
         ST_DIST: begin
            if (accept) begin
               state_in = status.len_zero ? ST_LIT : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) begin
               state_in = status.copy_last ? ST_LIT : ST_READ;
            end
         end
         default: begin
            state_in = ST_LIT;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready      = 1'b0;
      cmd            = '0;
      case (state_ff)
         ST_LIT: begin
            req_ready    = status.out_free;
            cmd.lit_load = req_valid && status.out_free && !status.is_esc;
         end
         ST_ESC: begin
            req_ready     = status.out_free;
            cmd.lit_load  = req_valid && status.out_free && status.is_esc;
            cmd.hold_dist = req_valid && status.out_free && !status.is_esc && !req_block_end;
         end
         ST_DIST: begin
            req_ready      = status.out_free;
            cmd.start_copy = req_valid && status.out_free;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
         end
         ST_WRITE: begin
            cmd.copy_emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/lzd_dp.sv =====
module lzd_dp #(
   parameter int COPY_LIMIT = lzd_pkg::MAX_COPY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [lzd_pkg::BYTE_W-1:0]  csr_wr_data,
   input  logic [lzd_pkg::BYTE_W-1:0]  req_comp_byte,
   input  lzd_pkg::lzd_cmd_type        cmd,
   output lzd_pkg::lzd_status_type     status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lzd_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_run_last,
   output logic                        rsp_length_error
);
   import lzd_pkg::*;

   localparam logic [BYTE_W-1:0] MaxCopyByte = BYTE_W'(COPY_LIMIT);

   logic [BYTE_W-1:0]        esc_ff, esc_in;
   logic [BYTE_W-1:0]        dist_ff, dist_in;
   logic [RING_AW-1:0]       wp_ff, wp_in;
   logic [BYTE_W-1:0]        rem_ff, rem_in;
   logic                     err_ff, err_in;
   logic [HISTORY_DEPTH-1:0] vld_ff, vld_in;
   logic [BYTE_W-1:0]        rd_mem_ff;
   logic                     rd_zero_ff, rd_zero_in;
   logic                     out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]        out_byte_ff, out_byte_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_err_ff, out_err_in;

   logic [BYTE_W-1:0]        ring_mem [HISTORY_DEPTH];
   logic [RING_AW-1:0]       rd_addr;
   logic                     ring_we;
   logic [BYTE_W-1:0]        wr_byte;
   logic [BYTE_W-1:0]        copy_byte;
   logic                     len_over;

   assign len_over  = req_comp_byte > MaxCopyByte;
   assign rd_addr   = wp_ff - RING_AW'(dist_ff);
   assign copy_byte = rd_zero_ff ? '0 : rd_mem_ff;
   assign ring_we   = cmd.lit_load || cmd.copy_emit;
   assign wr_byte   = cmd.copy_emit ? copy_byte : req_comp_byte;

   assign status.is_esc    = req_comp_byte == esc_ff;
   assign status.len_zero  = req_comp_byte == '0;
   assign status.copy_last = rem_ff == BYTE_W'(1);
   assign status.out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      esc_in       = csr_wr_en ? csr_wr_data : esc_ff;
      dist_in      = cmd.hold_dist ? req_comp_byte : dist_ff;
      wp_in        = ring_we ? wp_ff + RING_AW'(1) : wp_ff;
      rem_in       = rem_ff;
      err_in       = err_ff;
      if (cmd.start_copy) begin
         rem_in = len_over ? MaxCopyByte : req_comp_byte;
         err_in = len_over;
      end else if (cmd.copy_emit) begin
         rem_in = rem_ff - BYTE_W'(1);
      end
      vld_in = vld_ff;
      if (ring_we) begin
         vld_in[wp_ff] = 1'b1;
      end
      // Distance zero and never-written slots read as zero.
      rd_zero_in = (dist_ff == '0) || !vld_ff[rd_addr];
      out_valid_in = ring_we ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_byte_in  = ring_we ? wr_byte : out_byte_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      if (ring_we) begin
         out_last_in = cmd.lit_load ? 1'b1 : status.copy_last;
         out_err_in  = cmd.lit_load ? 1'b0 : err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff       <= '0;
         dist_ff      <= '0;
         wp_ff        <= '0;
         rem_ff       <= '0;
         err_ff       <= 1'b0;
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         esc_ff       <= esc_in;
         dist_ff      <= dist_in;
         wp_ff        <= wp_in;
         rem_ff       <= rem_in;
         err_ff       <= err_in;
         vld_ff       <= vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff] <= wr_byte;
      end
      if (cmd.rd_issue) begin
         rd_mem_ff  <= ring_mem[rd_addr];
         rd_zero_ff <= rd_zero_in;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_run_last     = out_last_ff;
   assign rsp_length_error = out_err_ff;

endmodule

// ===== src/lzd_checker.sv =====
`include "lz_escape_token_decoder_assert.svh"

module lzd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [lzd_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                       rsp_run_last,
   input logic                       rsp_length_error
);

   // Stalled response holds
   `LZD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last) && $stable(rsp_length_error), "stalled response changed")

   // A copy in flight blocks the request side
   `LZD_ASSERT_NOW(a_copy_blocks_req, rsp_valid && !rsp_run_last, !req_ready, "request taken mid-copy")

   // A new request never leaves a stale mid-copy byte behind
   `LZD_ASSERT_NEXT(a_req_after_copy, req_valid && req_ready, !rsp_valid || rsp_run_last, "mid-copy byte after request")

endmodule

bind lz_escape_token_decoder lzd_checker u_lzd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_out_byte     (rsp_chan.out_byte),
   .rsp_run_last     (rsp_chan.run_last),
   .rsp_length_error (rsp_chan.length_error)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import lzd_pkg::*;

   // Escape value used by the directed script.
   localparam logic [7:0] ESC_D = 8'h1B;
   // Give up after this many cycles with no request and no result moving.
   localparam int QUIET_LIMIT = 3000;
   // Let an in-flight zero-length token settle before touching the register.
   localparam int SETTLE_CYCLES = 8;
   // Long receiver hold-off used to back the block up into its input.
   localparam int LONG_HOLD = 300;
   // Random requests per escape setting.
   localparam int PHASE_REQUESTS = 96;

   typedef enum logic [1:0] {
      PARSE_IDLE,
      PARSE_ESC,
      PARSE_DIST
   } parse_phase_type;

   // One decoded output byte as it appears on the result channel.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       length_error;
   } out_byte_type;

   // One row of the directed script. When typed is set, the row carries its own
   // expected results: n_out copies of t_byte, each with length_error t_err.
   typedef struct packed {
      logic [7:0] code;
      logic       blk_end;
      logic       typed;
      logic [6:0] n_out;
      logic [7:0] t_byte;
      logic       t_err;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [27] = '{
      // back-reference right after reset: ring is all zero
      '{ESC_D, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'h05, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'h03, 1'b0, 1'b1, 7'd3, 8'h00, 1'b0},
      // literal extremes, and a literal that closes a block
      '{8'h00, 1'b0, 1'b1, 7'd1, 8'h00, 1'b0},
      '{8'hFF, 1'b0, 1'b1, 7'd1, 8'hFF, 1'b0},
      '{8'h41, 1'b0, 1'b0, 7'd0, 8'h00, 1'b0},
      '{8'h42, 1'b1, 1'b1, 7'd1, 8'h42, 1'b0},
      // doubled escape gives one escape byte
      '{ESC_D, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{ESC_D, 1'b0, 1'b1, 7'd1, ESC_D, 1'b0},
      // overlapping copy: distance 3, length 6
      '{ESC_D, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'h03, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'h06, 1'b0, 1'b0, 7'd0, 8'h00, 1'b0},
      // distance zero copies zeros
      '{ESC_D, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'h00, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'h05, 1'b0, 1'b1, 7'd5, 8'h00, 1'b0},
      // length 255 is clamped; the length byte also ends the block
      '{ESC_D, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'h01, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'hFF, 1'b1, 1'b1, 7'(MAX_COPY), 8'h00, 1'b1},
      // zero length gives nothing
      '{ESC_D, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'h04, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'h00, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      // token cut off on the escape, then on the distance
      '{ESC_D, 1'b1, 1'b1, 7'd0, 8'h00, 1'b0},
      '{ESC_D, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'h80, 1'b1, 1'b1, 7'd0, 8'h00, 1'b0},
      // farthest distance at exactly the copy limit
      '{ESC_D, 1'b0, 1'b1, 7'd0, 8'h00, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 7'd0, 8'h00, 1'b0},
      '{8'd64, 1'b0, 1'b0, 7'd0, 8'h00, 1'b0}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [BYTE_W-1:0] csr_wr_data;

   lzd_req_if req_bus ();
   lzd_rsp_if rsp_bus ();

   lz_escape_token_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Decoder shadow state.
   logic [7:0]      escape_now;
   parse_phase_type phase_now;
   logic [7:0]      pending_dist;
   logic [7:0]      history [HISTORY_DEPTH];
   logic [7:0]      wr_ptr;
   out_byte_type    step_bytes [$];

   // Bytes still owed by the block, oldest first.
   out_byte_type expected_bytes [$];
   int           errors;
   int           quiet_cycles;
   bit           hold_off_asked;

   // Gap pacing for each side: runs of gap-free items and runs of random gaps, picked at random.
   int tx_run;
   bit tx_steady;
   int rx_run;
   bit rx_steady;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int draw_gap(inout int run_left, inout bit steady);
      if (run_left == 0) begin
         run_left = $urandom_range(8, 40);
         steady = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      return steady ? 0 : $urandom_range(0, 8);
   endfunction

   // Append one output byte to the history and to this request's results.
   function automatic void keep_byte(input logic [7:0] v, input logic last,
                                     input logic err);
      out_byte_type r;
      history[wr_ptr] = v;
      wr_ptr++;
      r.out_byte = v;
      r.run_last = last;
      r.length_error = err;
      step_bytes.push_back(r);
   endfunction

   // Advance the shadow decoder by one compressed byte; results land in step_bytes.
   function automatic void decode_byte(input logic [7:0] b, input logic blk_end);
      int unsigned len;
      logic        err;
      logic [7:0]  start;
      logic [7:0]  v;
      step_bytes.delete();
      case (phase_now)
         PARSE_ESC: begin
            if (b == escape_now) begin
               keep_byte(b, 1'b1, 1'b0);
               phase_now = PARSE_IDLE;
            end else if (blk_end) begin
               // token cut off by the block end: drop it
               phase_now = PARSE_IDLE;
            end else begin
               pending_dist = b;
               phase_now = PARSE_DIST;
            end
         end
         PARSE_DIST: begin
            len = 32'(b);
            err = (len > MAX_COPY);
            if (err) len = MAX_COPY;
            start = wr_ptr;
            for (int i = 0; i < len; i++) begin
               // distance zero reads as zero; the ring wraps on 8 bits
               v = (pending_dist == 8'd0) ? 8'd0 : history[start - pending_dist + 8'(i)];
               keep_byte(v, (i + 1 == len), err);
            end
            phase_now = PARSE_IDLE;
         end
         default: begin
            phase_now = PARSE_IDLE;
            if (b == escape_now) begin
               if (!blk_end) phase_now = PARSE_ESC;
            end else begin
               keep_byte(b, 1'b1, 1'b0);
            end
         end
      endcase
   endfunction

   function automatic void note_mismatch(input string what, input int want, input int got);
      errors++;
      if (errors <= 40) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      end
   endfunction

   function automatic void check_result();
      out_byte_type want;
      if (expected_bytes.size() == 0) begin
         errors++;
         if (errors <= 40) begin
            $display("%0t: result out_byte %0h with nothing expected, expected none actual %0h",
                     $time, rsp_bus.out_byte, rsp_bus.out_byte);
         end
         return;
      end
      want = expected_bytes.pop_front();
      if (rsp_bus.out_byte !== want.out_byte)
         note_mismatch("out_byte", int'(want.out_byte), int'(rsp_bus.out_byte));
      if (rsp_bus.run_last !== want.run_last)
         note_mismatch("run_last", int'(want.run_last), int'(rsp_bus.run_last));
      if (rsp_bus.length_error !== want.length_error)
         note_mismatch("length_error", int'(want.length_error),
                       int'(rsp_bus.length_error));
   endfunction

   // Offer one request after a random gap; hold it until accepted, then log its
   // expected results. Enter and leave at a falling edge.
   task automatic put_request(input plan_row_type row);
      int n;
      n = draw_gap(tx_run, tx_steady);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.comp_byte <= row.code;
      req_bus.block_end <= row.blk_end;
      do @(posedge clock); while (!req_bus.ready);
      // accepted at this edge: advance the shadow decoder
      decode_byte(row.code, row.blk_end);
      if (row.typed) begin
         for (int i = 0; i < row.n_out; i++) begin
            expected_bytes.push_back('{row.t_byte, (i + 1 == row.n_out), row.t_err});
         end
      end else begin
         foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
      end
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic blk_end, inout int sent);
      plan_row_type row;
      row = '0;
      row.code = b;
      row.blk_end = blk_end;
      put_request(row);
      sent++;
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == escape_now);
      return v;
   endfunction

   // Drain, idle and write the escape register.
   task automatic program_escape(input logic [7:0] value);
      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      escape_now = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly well-formed tokens with random content; the rest is cut-off tokens
   // and raw noise bytes.
   task automatic random_token(inout int sent);
      int         kind;
      logic [7:0] dist_byte;
      logic [7:0] len;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         send_byte(plain_byte(), ($urandom_range(0, 15) == 0), sent);
      end else if (kind < 50) begin
         send_byte(escape_now, 1'b0, sent);
         send_byte(escape_now, 1'($urandom_range(0, 1)), sent);
      end else if (kind < 85) begin
         dist_byte = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 16))
                                                 : 8'($urandom_range(0, 255));
         len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 12));
         send_byte(escape_now, 1'b0, sent);
         send_byte(dist_byte, 1'b0, sent);
         send_byte(len, ($urandom_range(0, 7) == 0), sent);
      end else if (kind < 92) begin
         send_byte(escape_now, 1'($urandom_range(0, 1)), sent);
         // a distance byte that ends the block, unless the escape already did
         if (phase_now == PARSE_ESC) send_byte(plain_byte(), 1'b1, sent);
      end else begin
         send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), sent);
      end
   endtask

   // Result side: accept, check, and watch for a stuck block.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_result();
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Receiver: random stalls per result, and one long hold-off on request.
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = draw_gap(rx_run, rx_steady);
         if (hold_off_asked) begin
            hold_off_asked = 1'b0;
            n = LONG_HOLD;
         end
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   // Main sequence: reset, directed script, then random phases per escape value.
   initial begin
      int         sent;
      logic [7:0] esc_value;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.comp_byte = '0;
      req_bus.block_end = 1'b0;
      rsp_bus.ready = 1'b0;
      escape_now = 8'h00;
      phase_now = PARSE_IDLE;
      pending_dist = 8'h00;
      wr_ptr = 8'h00;
      foreach (history[i]) history[i] = 8'h00;
      errors = 0;
      hold_off_asked = 1'b0;
      tx_run = 0;
      rx_run = 0;
      tx_steady = 1'b0;
      rx_steady = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      program_escape(ESC_D);
      foreach (DIRECTED_PLAN[i]) put_request(DIRECTED_PLAN[i]);

      for (int phase = 0; phase < 4; phase++) begin
         // cover both register extremes, then random values
         case (phase)
            0: esc_value = 8'h00;
            1: esc_value = 8'hFF;
            default: esc_value = 8'($urandom_range(0, 255));
         endcase
         program_escape(esc_value);
         // back the block up once while the sender keeps offering
         if (phase == 1) hold_off_asked = 1'b1;
         sent = 0;
         while (sent < PHASE_REQUESTS) random_token(sent);
         // close any open token so the parser is idle before the next write
         send_byte(plain_byte(), 1'b1, sent);
      end

      req_bus.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
